// File: rtl/adts_pkg.sv
// Shared types, codes and tables of the ADTS frame synchroniser.
package adts_pkg;

    localparam int BUF_BYTES_DEF = 16384;
    localparam int MAX_FRAME_DEF = 8192;

    localparam logic [1:0] REQ_STREAM = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_PULL   = 2'd2;

    localparam logic [7:0] SYNC_HI    = 8'hFF;
    localparam logic [7:0] SYNC_MASK  = 8'hF6;
    localparam logic [7:0] SYNC_LO    = 8'hF0;
    localparam logic [3:0] RATE_LIMIT = 4'd13;
    localparam logic [12:0] MIN_FLEN  = 13'd7;
    localparam logic [2:0] HDR_LAST   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_HUNT, S_HRD, S_HCAP, S_HCHK, S_S0RD, S_S1RD, S_SCHK,
        S_ACC, S_ERD, S_ECAP, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_HDR, RD_SYNC0, RD_SYNC1, RD_EMIT
    } rd_sel_t;

    typedef struct packed {
        logic    store_byte;
        logic    set_end;
        logic    clr_k;
        logic    cap_hdr;
        logic    cap_sync0;
        logic    adv1;
        logic    accept;
        logic    cap_emit;
        logic    out_empty;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic phase;
        logic rem_nz;
        logic fill_ge7;
        logic k_zero;
        logic k_last;
        logic rdata_ff;
        logic hdr_ok;
        logic fits_sync;
        logic can_end;
        logic sync_ok;
    } sts_t;

    function automatic logic [16:0] rate_lookup(input logic [3:0] rix);
        logic [16:0] r;
        begin
            case (rix)
                4'd0:    r = 17'd96000;
                4'd1:    r = 17'd88200;
                4'd2:    r = 17'd64000;
                4'd3:    r = 17'd48000;
                4'd4:    r = 17'd44100;
                4'd5:    r = 17'd32000;
                4'd6:    r = 17'd24000;
                4'd7:    r = 17'd22050;
                4'd8:    r = 17'd16000;
                4'd9:    r = 17'd12000;
                4'd10:   r = 17'd11025;
                4'd11:   r = 17'd8000;
                4'd12:   r = 17'd7350;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/adts_ctrl.sv
// Controller state machine: sequences store, hunt, sync check and emit steps.
module adts_ctrl
    import adts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] req_type,
    input  logic       out_ready,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       in_ready,
    output logic       out_valid
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && req_type == REQ_PULL)
                begin
                    state_next = S_HUNT;
                end
            end
            S_HUNT:
            begin
                if (sts.phase)
                begin
                    state_next = sts.rem_nz ? S_ERD : S_OUT;
                end
                else if (!sts.fill_ge7)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                state_next = S_HCAP;
            end
            S_HCAP:
            begin
                if (sts.k_zero && !sts.rdata_ff)
                begin
                    state_next = S_HUNT;
                end
                else if (sts.k_last)
                begin
                    state_next = S_HCHK;
                end
                else
                begin
                    state_next = S_HRD;
                end
            end
            S_HCHK:
            begin
                if (!sts.hdr_ok)
                begin
                    state_next = S_HUNT;
                end
                else if (sts.fits_sync)
                begin
                    state_next = S_S0RD;
                end
                else if (sts.can_end)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_S0RD:  state_next = S_S1RD;
            S_S1RD:  state_next = S_SCHK;
            S_SCHK:  state_next = sts.sync_ok ? S_ACC : S_HUNT;
            S_ACC:   state_next = S_HUNT;
            S_ERD:   state_next = S_ECAP;
            S_ECAP:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.rd_sel = RD_HDR;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store_byte = (req_type == REQ_STREAM);
                    cmd.set_end    = (req_type == REQ_END);
                end
            end
            S_HUNT:
            begin
                if (sts.phase)
                begin
                    cmd.out_empty = !sts.rem_nz;
                end
                else if (!sts.fill_ge7)
                begin
                    cmd.out_empty = 1'b1;
                end
                else
                begin
                    cmd.clr_k = 1'b1;
                end
            end
            S_HRD:   cmd.rd_sel = RD_HDR;
            S_HCAP:
            begin
                cmd.cap_hdr = 1'b1;
                cmd.adv1    = sts.k_zero && !sts.rdata_ff;
            end
            S_HCHK:
            begin
                cmd.adv1      = !sts.hdr_ok;
                cmd.out_empty = sts.hdr_ok && !sts.fits_sync && !sts.can_end;
            end
            S_S0RD:  cmd.rd_sel = RD_SYNC0;
            S_S1RD:
            begin
                cmd.rd_sel    = RD_SYNC1;
                cmd.cap_sync0 = 1'b1;
            end
            S_SCHK:  cmd.adv1 = !sts.sync_ok;
            S_ACC:   cmd.accept = 1'b1;
            S_ERD:   cmd.rd_sel = RD_EMIT;
            S_ECAP:  cmd.cap_emit = 1'b1;
            S_OUT:   out_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

// File: rtl/adts_dpath.sv
// Datapath: ring buffer, pointers, header fields and result registers.
module adts_dpath
    import adts_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [7:0]  in_byte,
    output sts_t        sts,
    output logic        byte_valid,
    output logic [7:0]  payload_byte,
    output logic        first_of_frame,
    output logic        last_of_frame,
    output logic [1:0]  frame_profile,
    output logic [16:0] sample_rate_hz,
    output logic [3:0]  channel_count,
    output logic        overflow
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int FW = $clog2(BUF_BYTES + 1);
    localparam logic [AW:0] BUF_W = (AW + 1)'(BUF_BYTES);
    localparam logic [FW-1:0] BUF_F = FW'(BUF_BYTES);
    localparam logic [13:0] MAX_W = 14'(MAX_FRAME);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [13:0] n);
        logic [AW:0] s;
        begin
            s = {1'b0, p} + (AW + 1)'(n);
            return (s >= BUF_W) ? AW'(s - BUF_W) : AW'(s);
        end
    endfunction

    logic [7:0]    mem [BUF_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic [AW-1:0] wp_reg, hp_reg, ep_reg;
    logic [FW-1:0] fill_reg;
    logic [12:0]   cand_reg, rem_reg;
    logic [3:0]    hb_reg;
    logic          phase_reg, latched_reg, ended_reg, dropped_reg;
    logic [1:0]    prof_reg;
    logic [16:0]   rate_reg;
    logic [3:0]    ch_reg;
    logic [2:0]    k_reg;
    logic [7:0]    hdr_reg [6];
    logic [7:0]    s0_reg;
    logic          bv_reg, first_reg, last_reg;
    logic [7:0]    pb_reg;

    logic [3:0]    rix;
    logic [2:0]    chc;
    logic [12:0]   flen;
    logic [3:0]    hb_calc;
    logic          short_frame;

    assign rix     = hdr_reg[2][5:2];
    assign chc     = {hdr_reg[2][0], hdr_reg[3][7:6]};
    assign flen    = {hdr_reg[3][1:0], hdr_reg[4], hdr_reg[5][7:5]};
    assign hb_calc = hdr_reg[1][0] ? 4'd7 : 4'd9;
    assign short_frame = (flen <= 13'(hb_calc));

    assign mem_we = cmd.store_byte && !ended_reg && (fill_reg != BUF_F);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HDR:   rd_addr = wrap_add(hp_reg, 14'(k_reg));
            RD_SYNC0: rd_addr = wrap_add(hp_reg, {1'b0, flen});
            RD_SYNC1: rd_addr = wrap_add(hp_reg, 14'({1'b0, flen} + 14'd1));
            RD_EMIT:  rd_addr = ep_reg;
            default:  rd_addr = hp_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= in_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        sts.phase     = phase_reg;
        sts.rem_nz    = (rem_reg != 13'd0);
        sts.fill_ge7  = (fill_reg >= FW'(7));
        sts.k_zero    = (k_reg == 3'd0);
        sts.k_last    = (k_reg == HDR_LAST);
        sts.rdata_ff  = (rdata_reg == SYNC_HI);
        sts.hdr_ok    = (hdr_reg[0] == SYNC_HI) && ((hdr_reg[1] & SYNC_MASK) == SYNC_LO)
                        && (rix < RATE_LIMIT) && (chc != 3'd0) && (flen >= MIN_FLEN)
                        && ({1'b0, flen} <= MAX_W);
        sts.fits_sync = (FW'(flen) + FW'(2) <= fill_reg);
        sts.can_end   = ended_reg && (FW'(flen) <= fill_reg);
        sts.sync_ok   = (s0_reg == SYNC_HI) && ((rdata_reg & SYNC_MASK) == SYNC_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            hp_reg      <= '0;
            ep_reg      <= '0;
            fill_reg    <= '0;
            cand_reg    <= '0;
            rem_reg     <= '0;
            hb_reg      <= 4'd7;
            phase_reg   <= 1'b0;
            latched_reg <= 1'b0;
            ended_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            prof_reg    <= '0;
            rate_reg    <= '0;
            ch_reg      <= '0;
            k_reg       <= '0;
            s0_reg      <= '0;
            bv_reg      <= 1'b0;
            first_reg   <= 1'b0;
            last_reg    <= 1'b0;
            pb_reg      <= '0;
            for (int i = 0; i < 6; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.store_byte && !ended_reg)
            begin
                if (fill_reg == BUF_F)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg   <= wrap_add(wp_reg, 14'd1);
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (cmd.set_end)
            begin
                ended_reg <= 1'b1;
            end
            if (cmd.clr_k)
            begin
                k_reg <= '0;
            end
            if (cmd.cap_hdr)
            begin
                hdr_reg[k_reg] <= rdata_reg;
                k_reg          <= k_reg + 3'd1;
            end
            if (cmd.cap_sync0)
            begin
                s0_reg <= rdata_reg;
            end
            if (cmd.adv1)
            begin
                hp_reg   <= wrap_add(hp_reg, 14'd1);
                fill_reg <= fill_reg - FW'(1);
            end
            if (cmd.accept)
            begin
                if (!latched_reg)
                begin
                    rate_reg    <= rate_lookup(rix);
                    ch_reg      <= (chc == 3'd7) ? 4'd8 : {1'b0, chc};
                    latched_reg <= 1'b1;
                end
                prof_reg <= hdr_reg[2][7:6];
                hb_reg   <= hb_calc;
                if (short_frame)
                begin
                    hp_reg   <= wrap_add(hp_reg, {1'b0, flen});
                    fill_reg <= fill_reg - FW'(flen);
                end
                else
                begin
                    cand_reg  <= flen;
                    ep_reg    <= wrap_add(hp_reg, 14'(hb_calc));
                    rem_reg   <= flen - 13'(hb_calc);
                    phase_reg <= 1'b1;
                end
            end
            if (cmd.cap_emit)
            begin
                bv_reg    <= 1'b1;
                pb_reg    <= rdata_reg;
                first_reg <= (rem_reg == cand_reg - 13'(hb_reg));
                last_reg  <= (rem_reg == 13'd1);
                ep_reg    <= wrap_add(ep_reg, 14'd1);
                rem_reg   <= rem_reg - 13'd1;
                if (rem_reg == 13'd1)
                begin
                    hp_reg    <= wrap_add(hp_reg, {1'b0, cand_reg});
                    fill_reg  <= fill_reg - FW'(cand_reg);
                    phase_reg <= 1'b0;
                end
            end
            if (cmd.out_empty)
            begin
                bv_reg    <= 1'b0;
                pb_reg    <= '0;
                first_reg <= 1'b0;
                last_reg  <= 1'b0;
            end
        end
    end

    assign byte_valid     = bv_reg;
    assign payload_byte   = pb_reg;
    assign first_of_frame = first_reg;
    assign last_of_frame  = last_reg;
    assign frame_profile  = prof_reg;
    assign sample_rate_hz = rate_reg;
    assign channel_count  = ch_reg;
    assign overflow       = dropped_reg;

endmodule

// File: rtl/adts_frame_sync_deframer_core.sv
// Top level of the ADTS frame synchroniser and deframer.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | req_type, in_byte
//  out     | out_valid / out_ready| byte_valid, payload_byte, first_of_frame,
//          |                      | last_of_frame, frame_profile, sample_rate_hz,
//          |                      | channel_count, overflow
//
// Stream-byte, end and unused requests are taken in S_IDLE and give no result.
// A pull request goes from S_IDLE to the hunt and then to S_OUT; reading a payload byte
// passes through S_ERD and S_ECAP. Each hunt step reads header bytes through S_HRD and
// S_HCAP, drops a byte that is not 0xFF on its first read, checks the header in S_HCHK,
// the next-frame sync in S_S0RD, S_S1RD and S_SCHK, and accepts in S_ACC.
// Reset clears all control state; the buffer needs no clearing pass.
// One request is in flight at a time: in_ready is low from a pull request
// until its result is taken, so a stalled output holds the block.
module adts_frame_sync_deframer_core
    import adts_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  payload_byte,
    output logic        first_of_frame,
    output logic        last_of_frame,
    output logic [1:0]  frame_profile,
    output logic [16:0] sample_rate_hz,
    output logic [3:0]  channel_count,
    output logic        overflow
);

    cmd_t cmd;
    sts_t sts;

    // Sequence each request: store bytes, hunt, confirm sync, emit.
    adts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    // Hold the ring buffer, pointers and result registers.
    adts_dpath #(
        .BUF_BYTES (BUF_BYTES),
        .MAX_FRAME (MAX_FRAME)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_byte        (in_byte),
        .sts            (sts),
        .byte_valid     (byte_valid),
        .payload_byte   (payload_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .frame_profile  (frame_profile),
        .sample_rate_hz (sample_rate_hz),
        .channel_count  (channel_count),
        .overflow       (overflow)
    );

endmodule

// File: rtl/adts_checker.sv
// Port-level checker for the ADTS frame synchroniser, bound to the top level.
module adts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        byte_valid,
    input logic [7:0]  payload_byte,
    input logic        first_of_frame,
    input logic        last_of_frame,
    input logic [16:0] sample_rate_hz,
    input logic        overflow
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (payload_byte == 8'd0 && !first_of_frame
                                        && !last_of_frame))
        else $error("empty result carries byte data");

    a_rate_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_rate_hz != 17'd0) |=> (sample_rate_hz == $past(sample_rate_hz)))
        else $error("latched rate changed");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |=> overflow)
        else $error("overflow flag cleared");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte)))
        else $error("stalled result changed");

endmodule

bind adts_frame_sync_deframer_core adts_checker u_adts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_valid     (byte_valid),
    .payload_byte   (payload_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .sample_rate_hz (sample_rate_hz),
    .overflow       (overflow)
);
